// File: src/gfd_pkg.sv
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, constants and arithmetic helpers of the glider flight
// derivative pipeline.
// ----------------------------------------------------------------------------
package gfd_pkg;

	localparam int BANK_ENTRIES = 64;
	localparam int BANK_AW      = (BANK_ENTRIES > 1) ? $clog2(BANK_ENTRIES) : 1;
	localparam logic signed [8:0] BANK_LAST = 9'(BANK_ENTRIES - 1);

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int LATE_STAGES = 8;
	// accept edge to the edge at which the result is taken
	localparam int PIPE_DEPTH = 3 + SQRT_STEPS + DIV_STEPS + LATE_STAGES + 1;

	localparam logic signed [57:0] GRAVITY_ONE = 58'sd65536;

	localparam logic [1:0] REG_LIFT = 2'd0;
	localparam logic [1:0] REG_DRAG = 2'd1;
	localparam logic [1:0] REG_BANK = 2'd2;

	localparam logic MODE_EVAL = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO_H = 2'd1;
	localparam logic [1:0] ST_BANK   = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [17:0] cs;
		logic signed [17:0] sn;
		logic               satf;
		logic               bankf;
	} side_t;

	typedef struct packed {
		side_t       side;
		logic [31:0] v;
		logic        zeroh;
	} late_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] xs;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] q;
		logic        nbit;
		logic        neg;
	} div_t;

	// one digit of the integer square root, two radicand bits a step
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		logic [35:0] sh;
		logic [35:0] trial;
		sqrt_t       r;
		sh    = {a.rem, a.xs[63:62]};
		trial = {2'b00, a.root, 2'b01};
		r.xs  = {a.xs[61:0], 2'b00};
		if (sh >= trial) begin
			r.rem  = 34'(sh - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = sh[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of a restoring division
	function automatic div_t div_step(input div_t a, input logic [31:0] d);
		logic [32:0] sh;
		div_t        r;
		sh     = {a.rem, a.nbit};
		r.nbit = 1'b0;
		r.neg  = a.neg;
		if (sh >= {1'b0, d}) begin
			r.rem = 32'(sh - {1'b0, d});
			r.q   = {a.q[29:0], 1'b1};
		end else begin
			r.rem = sh[31:0];
			r.q   = {a.q[29:0], 1'b0};
		end
		return r;
	endfunction

	// shift right, magnitude truncated towards zero
	function automatic logic signed [95:0] tz(input logic signed [95:0] p, input int sh);
		logic signed [95:0] r;
		if (p < 0) r = -((-p) >>> sh);
		else       r = p >>> sh;
		return r;
	endfunction

	// {overflow, value} saturated to 32 bit signed
	function automatic logic [32:0] sat32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sh7fffffff)       r = {1'b1, 32'h7fffffff};
		else if (x < -64'sh80000000) r = {1'b1, 32'h80000000};
		else                         r = {1'b0, x[31:0]};
		return r;
	endfunction

endpackage

// File: src/glider_flight_derivative.sv
// ----------------------------------------------------------------------------
// glider_flight_derivative
// Time derivative of a glider's state in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: one item may be started in every cycle (busy stays low). An evaluate
// item (mode 0) gives one result at the end of the pipeline, marked by done
// for one cycle; the receiver cannot stall it, so take it then. A load item
// (mode 1) writes one cos/sin entry of the bank table and gives no result;
// an evaluate may read it from the next cycle on. The pipeline is made of
// the two integer square roots (32 stages, one root bit a stage) and the
// two divisions for the unit direction (31 stages, one quotient bit a
// stage), plus input, squaring and eight multiply/normalise stages. Reading
// a table entry that was never loaded gives undefined accelerations. Write
// the configuration only when no evaluate is in flight.
// ----------------------------------------------------------------------------
module glider_flight_derivative (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  vel_z,
	input  logic signed [31:0]  wind_x,
	input  logic signed [31:0]  wind_y,
	input  logic signed [31:0]  wind_z,
	input  logic signed [6:0]   bank_index,
	input  logic signed [17:0]  load_cosine,
	input  logic signed [17:0]  load_sine,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	output logic                done,
	output logic signed [31:0]  pos_rate_x,
	output logic signed [31:0]  pos_rate_y,
	output logic signed [31:0]  pos_rate_z,
	output logic signed [31:0]  accel_x,
	output logic signed [31:0]  accel_y,
	output logic signed [31:0]  accel_z,
	output logic [1:0]          status
);
	import gfd_pkg::*;

	// ---------------- configuration ----------------
	logic [19:0]        lift_q;
	logic [19:0]        drag_q;
	logic signed [6:0]  bank_low_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_q     <= 20'd65536;
			drag_q     <= 20'd6554;
			bank_low_q <= -7'sd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIFT: lift_q     <= cfg_data;
				REG_DRAG: drag_q     <= cfg_data;
				REG_BANK: bank_low_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------- bank table ----------------
	logic               take;
	logic signed [8:0]  diff;
	logic [BANK_AW-1:0] rd_addr;
	logic               bank_out;
	logic [35:0]        trig_mem [BANK_ENTRIES];
	logic [35:0]        rd_q;

	assign take = start && !busy;
	// entry address relative to the lowest stored bank step
	assign diff = 9'(bank_index) - 9'(bank_low_q);

	always_comb begin
		bank_out = 1'b0;
		rd_addr  = diff[BANK_AW-1:0];
		if (diff < 0) begin
			bank_out = 1'b1;
			rd_addr  = '0;
		end else if (diff > BANK_LAST) begin
			bank_out = 1'b1;
			rd_addr  = BANK_LAST[BANK_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take && mode == MODE_LOAD && !bank_out)
			trig_mem[diff[BANK_AW-1:0]] <= {load_cosine, load_sine};
		if (take && mode == MODE_EVAL)
			rd_q <= trig_mem[rd_addr];
	end

	// ---------------- stage 1: relative velocity ----------------
	logic [32:0] rx_w, ry_w, rz_w;
	logic        v_s1;
	side_t       side_s1;

	assign rx_w = sat32(64'(vel_x) - 64'(wind_x));
	assign ry_w = sat32(64'(vel_y) - 64'(wind_y));
	assign rz_w = sat32(64'(vel_z) - 64'(wind_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= take && mode == MODE_EVAL;
	end

	always_ff @(posedge clk) begin
		side_s1.ux    <= vel_x;
		side_s1.uy    <= vel_y;
		side_s1.uz    <= vel_z;
		side_s1.rx    <= rx_w[31:0];
		side_s1.ry    <= ry_w[31:0];
		side_s1.rz    <= rz_w[31:0];
		side_s1.cs    <= '0;
		side_s1.sn    <= '0;
		side_s1.satf  <= rx_w[32] | ry_w[32] | rz_w[32];
		side_s1.bankf <= bank_out;
	end

	// ---------------- stage 2: squares, table data joins ----------------
	logic        v_s2;
	side_t       side_s2;
	side_t       side_join_w;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	// merge the table read into the side data
	always_comb begin
		side_join_w    = side_s1;
		side_join_w.cs = rd_q[35:18];
		side_join_w.sn = rd_q[17:0];
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_join_w;
		sqx_s2  <= side_s1.rx * side_s1.rx;
		sqy_s2  <= side_s1.ry * side_s1.ry;
		sqz_s2  <= side_s1.rz * side_s1.rz;
	end

	// ---------------- stage 3: sums of squares ----------------
	logic        v_s3;
	side_t       side_s3;
	logic [63:0] hh_s3, vv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		hh_s3   <= sqx_s2 + sqy_s2;
		vv_s3   <= sqx_s2 + sqy_s2 + sqz_s2;
	end

	// ---------------- square roots: one root bit a stage ----------------
	logic  sq_v    [SQRT_STEPS+1];
	side_t sq_side [SQRT_STEPS+1];
	sqrt_t sq_h    [SQRT_STEPS+1];
	sqrt_t sq_a    [SQRT_STEPS+1];

	assign sq_v[0]    = v_s3;
	assign sq_side[0] = side_s3;
	assign sq_h[0]    = '{rem: '0, root: '0, xs: hh_s3};
	assign sq_a[0]    = '{rem: '0, root: '0, xs: vv_s3};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else         sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			sq_side[k+1] <= sq_side[k];
			sq_h[k+1]    <= sqrt_step(sq_h[k]);
			sq_a[k+1]    <= sqrt_step(sq_a[k]);
		end
	end

	// ---------------- unit direction: one quotient bit a stage ----------------
	logic [31:0] absx_w, absy_w;
	logic        dv_v    [DIV_STEPS+1];
	side_t       dv_side [DIV_STEPS+1];
	logic [31:0] dv_h    [DIV_STEPS+1];
	logic [31:0] dv_a    [DIV_STEPS+1];
	div_t        dv_x    [DIV_STEPS+1];
	div_t        dv_y    [DIV_STEPS+1];

	assign absx_w = sq_side[SQRT_STEPS].rx[31] ? 32'(-sq_side[SQRT_STEPS].rx)
		: sq_side[SQRT_STEPS].rx;
	assign absy_w = sq_side[SQRT_STEPS].ry[31] ? 32'(-sq_side[SQRT_STEPS].ry)
		: sq_side[SQRT_STEPS].ry;

	assign dv_v[0]    = sq_v[SQRT_STEPS];
	assign dv_side[0] = sq_side[SQRT_STEPS];
	assign dv_h[0]    = sq_h[SQRT_STEPS].root;
	assign dv_a[0]    = sq_a[SQRT_STEPS].root;
	// dividend is |r| * 2^30; quotient bits above 30 are zero since |r| <= h
	assign dv_x[0] = '{rem: {1'b0, absx_w[31:1]}, q: '0, nbit: absx_w[0],
		neg: sq_side[SQRT_STEPS].rx[31]};
	assign dv_y[0] = '{rem: {1'b0, absy_w[31:1]}, q: '0, nbit: absy_w[0],
		neg: sq_side[SQRT_STEPS].ry[31]};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else         dv_v[k+1] <= dv_v[k];
		end
		always_ff @(posedge clk) begin
			dv_side[k+1] <= dv_side[k];
			dv_h[k+1]    <= dv_h[k];
			dv_a[k+1]    <= dv_a[k];
			dv_x[k+1]    <= div_step(dv_x[k], dv_h[k]);
			dv_y[k+1]    <= div_step(dv_y[k], dv_h[k]);
		end
	end

	// ---------------- late stages: side data travels along ----------------
	logic  lt_v [LATE_STAGES+1];
	late_t lt_s [LATE_STAGES+1];
	logic  zeroh_w;

	assign zeroh_w = dv_h[DIV_STEPS] == '0;
	assign lt_v[0] = dv_v[DIV_STEPS];
	assign lt_s[0] = '{side: dv_side[DIV_STEPS], v: dv_a[DIV_STEPS], zeroh: zeroh_w};

	for (genvar k = 0; k < LATE_STAGES; k++) begin : g_late
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lt_v[k+1] <= 1'b0;
			else         lt_v[k+1] <= lt_v[k];
		end
		always_ff @(posedge clk) begin
			lt_s[k+1] <= lt_s[k];
		end
	end

	// direction components, forced to zero with no horizontal airspeed
	logic signed [31:0] ex_w, ey_w;
	logic [31:0]        h_w;

	assign h_w  = dv_h[DIV_STEPS];
	assign ex_w = zeroh_w ? '0 : dv_x[DIV_STEPS].neg ? -$signed({1'b0, dv_x[DIV_STEPS].q})
		: $signed({1'b0, dv_x[DIV_STEPS].q});
	assign ey_w = zeroh_w ? '0 : dv_y[DIV_STEPS].neg ? -$signed({1'b0, dv_y[DIV_STEPS].q})
		: $signed({1'b0, dv_y[DIV_STEPS].q});

	// multiply 1: direction times rz and v, lift coefficient times h
	logic signed [63:0] p_exz_s1, p_eyz_s1;
	logic signed [64:0] p_exv_s1, p_eyv_s1;
	logic [51:0]        p_clh_s1;

	always_ff @(posedge clk) begin
		p_exz_s1 <= ex_w * lt_s[0].side.rz;
		p_eyz_s1 <= ey_w * lt_s[0].side.rz;
		p_exv_s1 <= ex_w * $signed({1'b0, lt_s[0].v});
		p_eyv_s1 <= ey_w * $signed({1'b0, lt_s[0].v});
		p_clh_s1 <= lift_q * h_w;
	end

	// normalise 1
	logic signed [32:0] a_exz_s2, a_eyz_s2;
	logic signed [33:0] a_exv_s2, a_eyv_s2;
	logic [35:0]        clh_s2;

	always_ff @(posedge clk) begin
		a_exz_s2 <= 33'(tz(96'(p_exz_s1), 30));
		a_eyz_s2 <= 33'(tz(96'(p_eyz_s1), 30));
		a_exv_s2 <= 34'(tz(96'(p_exv_s1), 30));
		a_eyv_s2 <= 34'(tz(96'(p_eyv_s1), 30));
		clh_s2   <= p_clh_s1[51:16];
	end

	// multiply 2: bank cosine and sine
	logic signed [50:0] q_exz_s3, q_eyz_s3;
	logic signed [51:0] q_exv_s3, q_eyv_s3;
	logic signed [54:0] q_z_s3;

	always_ff @(posedge clk) begin
		q_exz_s3 <= a_exz_s2 * lt_s[2].side.cs;
		q_eyz_s3 <= a_eyz_s2 * lt_s[2].side.cs;
		q_exv_s3 <= a_exv_s2 * lt_s[2].side.sn;
		q_eyv_s3 <= a_eyv_s2 * lt_s[2].side.sn;
		q_z_s3   <= $signed({1'b0, clh_s2}) * lt_s[2].side.cs;
	end

	// normalise 2 and form the lift sums
	logic signed [35:0] sx_s4, sy_s4;
	logic signed [38:0] lz_s4;

	always_ff @(posedge clk) begin
		sx_s4 <= 36'(tz(96'(q_exz_s3), 16)) + 36'(tz(96'(q_eyv_s3), 16));
		sy_s4 <= 36'(tz(96'(q_eyz_s3), 16)) - 36'(tz(96'(q_exv_s3), 16));
		lz_s4 <= 39'(tz(96'(q_z_s3), 16));
	end

	// multiply 3: lift and drag coefficients
	logic signed [56:0] px_s5, py_s5;
	logic signed [52:0] pdx_s5, pdy_s5, pdz_s5;
	logic signed [38:0] lz_s5;

	always_ff @(posedge clk) begin
		px_s5  <= $signed({1'b0, lift_q}) * sx_s4;
		py_s5  <= $signed({1'b0, lift_q}) * sy_s4;
		pdx_s5 <= $signed({1'b0, drag_q}) * lt_s[4].side.rx;
		pdy_s5 <= $signed({1'b0, drag_q}) * lt_s[4].side.ry;
		pdz_s5 <= $signed({1'b0, drag_q}) * lt_s[4].side.rz;
		lz_s5  <= lz_s4;
	end

	// normalise 3: bracketed force terms
	logic signed [39:0] inx_s6, iny_s6, inz_s6;

	always_ff @(posedge clk) begin
		inx_s6 <= 40'(tz(96'(px_s5), 16)) + 40'(tz(96'(pdx_s5), 16));
		iny_s6 <= 40'(tz(96'(py_s5), 16)) + 40'(tz(96'(pdy_s5), 16));
		inz_s6 <= 40'(lz_s5) - 40'(tz(96'(pdz_s5), 16));
	end

	// multiply 4: airspeed times the terms, split in two partial products
	logic [39:0] mx_w, my_w, mz_w;
	logic [51:0] mlo_x_s7, mlo_y_s7, mlo_z_s7;
	logic [50:0] mhi_x_s7, mhi_y_s7, mhi_z_s7;
	logic        ng_x_s7, ng_y_s7, ng_z_s7;

	assign mx_w = inx_s6[39] ? 40'(-inx_s6) : inx_s6;
	assign my_w = iny_s6[39] ? 40'(-iny_s6) : iny_s6;
	assign mz_w = inz_s6[39] ? 40'(-inz_s6) : inz_s6;

	always_ff @(posedge clk) begin
		mlo_x_s7 <= lt_s[6].v * mx_w[19:0];
		mlo_y_s7 <= lt_s[6].v * my_w[19:0];
		mlo_z_s7 <= lt_s[6].v * mz_w[19:0];
		mhi_x_s7 <= lt_s[6].v * mx_w[38:20];
		mhi_y_s7 <= lt_s[6].v * my_w[38:20];
		mhi_z_s7 <= lt_s[6].v * mz_w[38:20];
		ng_x_s7  <= inx_s6[39];
		ng_y_s7  <= iny_s6[39];
		ng_z_s7  <= inz_s6[39];
	end

	// combine partials, drop the fraction, restore the sign
	logic [71:0]        sum_x_w, sum_y_w, sum_z_w;
	logic signed [56:0] val_x_s8, val_y_s8, val_z_s8;

	assign sum_x_w = {1'b0, mhi_x_s7, 20'b0} + 72'(mlo_x_s7);
	assign sum_y_w = {1'b0, mhi_y_s7, 20'b0} + 72'(mlo_y_s7);
	assign sum_z_w = {1'b0, mhi_z_s7, 20'b0} + 72'(mlo_z_s7);

	always_ff @(posedge clk) begin
		val_x_s8 <= ng_x_s7 ? -$signed({1'b0, sum_x_w[71:16]}) : $signed({1'b0, sum_x_w[71:16]});
		val_y_s8 <= ng_y_s7 ? -$signed({1'b0, sum_y_w[71:16]}) : $signed({1'b0, sum_y_w[71:16]});
		val_z_s8 <= ng_z_s7 ? -$signed({1'b0, sum_z_w[71:16]}) : $signed({1'b0, sum_z_w[71:16]});
	end

	// ---------------- output register ----------------
	logic [32:0] ax_w, ay_w, az_w;
	logic        sat_w;
	late_t       fin;

	assign fin   = lt_s[LATE_STAGES];
	assign ax_w  = sat32(64'(-58'(val_x_s8)));
	assign ay_w  = sat32(64'(-58'(val_y_s8)));
	assign az_w  = sat32(64'(58'(val_z_s8) - GRAVITY_ONE));
	assign sat_w = fin.side.satf | ax_w[32] | ay_w[32] | az_w[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= lt_v[LATE_STAGES];
	end

	always_ff @(posedge clk) begin
		pos_rate_x <= fin.side.ux;
		pos_rate_y <= fin.side.uy;
		pos_rate_z <= fin.side.uz;
		accel_x    <= ax_w[31:0];
		accel_y    <= ay_w[31:0];
		accel_z    <= az_w[31:0];
		// saturation wins over bank range, which wins over zero airspeed
		if (sat_w)               status <= ST_SAT;
		else if (fin.side.bankf) status <= ST_BANK;
		else if (fin.zeroh)      status <= ST_ZERO_H;
		else                     status <= ST_OK;
	end

	// ---------------- assertions ----------------
	a_eval_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode == MODE_EVAL) |-> ##PIPE_DEPTH done)
		else $error("evaluate item gave no result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode == MODE_LOAD) |-> ##PIPE_DEPTH !done)
		else $error("load item gave a result");

	a_pos_rate: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pos_rate_z == $past(vel_z, PIPE_DEPTH))
		else $error("position rate does not match its item");

endmodule
